// File: src/bsws_pkg.sv
// ----------------------------------------------------------------------------
// Bounded stack package
// Shared constants, request codes and transfer types for the bounded stack.
// ----------------------------------------------------------------------------
package bsws_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int WORD_W        = 32;
  localparam int CAPACITY_W    = 9;
  localparam int COUNT_OUT_W   = 9;
  localparam int INDEX_OUT_W   = 8;
  localparam int KIND_W        = 3;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 9'd256;

  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     status;
    logic signed [WORD_W-1:0] data;
    logic [INDEX_OUT_W-1:0]   found_index;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     is_empty;
    logic                     is_full;
  } res_t;

endpackage

// File: src/bsws_mem.sv
// ----------------------------------------------------------------------------
// Bounded stack entry memory
// Single-port-write, single-port-read synchronous RAM with a registered read
// port that holds the stack entries.
// ----------------------------------------------------------------------------
module bsws_mem #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [bsws_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [bsws_pkg::WORD_W-1:0] rd_data
);

  logic [bsws_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/bounded_stack_with_search.sv
// ----------------------------------------------------------------------------
// Bounded stack with search
// LIFO stack of 32-bit words with a capacity register and a top-down search.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                      Transfer when
//   request   start, busy, cmd             start high and busy low
//   result    done, result                 done high (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// Push, clear, unknown requests and any request on an empty stack give their
// result in the next cycle, and a new request may follow at once. Pop and peek
// on a nonempty stack read the entry memory and hold busy in ST_READ. Search
// holds busy in ST_SCAN while the one read port of the entry memory scans
// one entry per cycle from the top down. The capacity register is written only
// while no request is in progress or being offered. Reset empties the stack
// and sets capacity to 256; the entry memory is not cleared.
//
module bounded_stack_with_search #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  bsws_pkg::cmd_t                  cmd,
  output logic                            done,
  output bsws_pkg::res_t                  result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsws_pkg::CAPACITY_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                        state, state_next;
  logic [CW-1:0]                     count, count_next;
  logic [bsws_pkg::CAPACITY_W-1:0]   capacity;
  logic [bsws_pkg::KIND_W-1:0]       op_kind, op_kind_next;
  logic [bsws_pkg::WORD_W-1:0]       key, key_next;
  logic [CW-1:0]                     scan_ptr, scan_ptr_next;
  logic [AW-1:0]                     rd_idx, rd_idx_next;
  logic                              done_next;
  bsws_pkg::res_t                    result_next;

  logic [CW-1:0]                     cap_eff;
  logic                              accept;
  logic                              op_status;
  logic [bsws_pkg::WORD_W-1:0]       op_data;
  logic [AW-1:0]                     op_found;

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [bsws_pkg::WORD_W-1:0]       rd_data;

  bsws_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign wr_addr   = AW'(count);
  assign cap_eff   = (32'(capacity) > DEPTH) ? CW'(DEPTH) : CW'(capacity);

  always_comb begin
    state_next    = state;
    count_next    = count;
    op_kind_next  = op_kind;
    key_next      = key;
    scan_ptr_next = scan_ptr;
    rd_idx_next   = rd_idx;
    done_next     = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = AW'(count - 1'b1);
    op_status     = 1'b1;
    op_data       = '0;
    op_found      = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_kind_next = cmd.kind;
          key_next     = cmd.value;
          unique case (cmd.kind) inside
            bsws_pkg::KIND_PUSH: begin
              done_next = 1'b1;
              if (count < cap_eff) begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
                op_status  = 1'b0;
              end
            end
            bsws_pkg::KIND_POP, bsws_pkg::KIND_PEEK: begin
              if (count != '0) begin
                rd_en      = 1'b1;
                state_next = ST_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            bsws_pkg::KIND_CLEAR: begin
              done_next  = 1'b1;
              count_next = '0;
              op_status  = 1'b0;
            end
            bsws_pkg::KIND_SEARCH: begin
              if (count != '0) begin
                rd_en         = 1'b1;
                rd_idx_next   = AW'(count - 1'b1);
                scan_ptr_next = count - 1'b1;
                state_next    = ST_SCAN;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done_next  = 1'b1;
        op_status  = 1'b0;
        op_data    = rd_data;
        state_next = ST_IDLE;
        if (op_kind == bsws_pkg::KIND_POP) begin
          count_next = count - 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_data == key) begin
          done_next  = 1'b1;
          op_status  = 1'b0;
          op_found   = rd_idx;
          state_next = ST_IDLE;
        end else if (scan_ptr == '0) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = AW'(scan_ptr - 1'b1);
          rd_idx_next   = AW'(scan_ptr - 1'b1);
          scan_ptr_next = scan_ptr - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    result_next.status      = op_status;
    result_next.data        = op_data;
    result_next.found_index = bsws_pkg::INDEX_OUT_W'(op_found);
    result_next.count       = bsws_pkg::COUNT_OUT_W'(count_next);
    result_next.is_empty    = (count_next == '0);
    result_next.is_full     = (count_next >= cap_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      capacity <= bsws_pkg::CAPACITY_RESET;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_kind  <= op_kind_next;
    key      <= key_next;
    scan_ptr <= scan_ptr_next;
    rd_idx   <= rd_idx_next;
    if (done_next) begin
      result <= result_next;
    end
  end

endmodule

// File: src/bsws_chk.sv
// ----------------------------------------------------------------------------
// Bounded stack port checker
// Concurrent checks on the ports of the bounded stack, bound to the top level.
// ----------------------------------------------------------------------------
module bsws_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input bsws_pkg::res_t result,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("Accepted request neither finished nor held busy.");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("Busy dropped without a result transfer.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.count == '0)))
    else $error("Empty flag disagrees with count.");

  a_failure_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.data == '0 && result.found_index == '0))
    else $error("Failed request returned nonzero data or index.");

  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (!busy && !start))
    else $error("Capacity written while a request was in progress or offered.");

endmodule

bind bounded_stack_with_search bsws_chk u_bsws_chk (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Bounded stack with search testbench
// Drives push, pop, peek, clear, search and unused requests through the
// start/busy port, rewrites the capacity register between phases, and checks
// every result against a scoreboard that tracks the stack contents.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsws_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEFAULT;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  class stack_scoreboard;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int held;
    int peak;
    logic [CAPACITY_W-1:0] cap_reg;
    res_t pending [$];
    int errors;
    int checked;
    int settings;
    int refused;
    int kind_seen [8];

    function new();
      held = 0;
      peak = 0;
      cap_reg = CAPACITY_RESET;
      errors = 0;
      checked = 0;
      settings = 1;
      refused = 0;
      foreach (words[i]) words[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_capacity(logic [CAPACITY_W-1:0] v);
      cap_reg = v;
      settings++;
    endfunction

    function void note_request(cmd_t c);
      res_t r;
      int lim;
      int i;
      lim = (cap_reg > STACK_DEPTH) ? STACK_DEPTH : int'(cap_reg);
      r = '0;
      r.status = 1'b1;
      kind_seen[c.kind]++;
      case (c.kind)
        KIND_PUSH: begin
          if (held < lim) begin
            words[held] = c.value;
            held++;
            r.status = 1'b0;
          end
        end
        KIND_POP: begin
          if (held > 0) begin
            held--;
            r.data = words[held];
            r.status = 1'b0;
          end
        end
        KIND_PEEK: begin
          if (held > 0) begin
            r.data = words[held - 1];
            r.status = 1'b0;
          end
        end
        KIND_CLEAR: begin
          held = 0;
          r.status = 1'b0;
        end
        KIND_SEARCH: begin
          for (i = held - 1; i >= 0; i--) begin
            if (words[i] == c.value) begin
              r.found_index = i[INDEX_OUT_W-1:0];
              r.status = 1'b0;
              break;
            end
          end
        end
        default: begin
        end
      endcase
      if (r.status && c.kind <= KIND_SEARCH) refused++;
      if (held > peak) peak = held;
      r.count = held[COUNT_OUT_W-1:0];
      r.is_empty = (held == 0);
      r.is_full = (held >= lim);
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, got %p", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  res_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAPACITY_W-1:0] cfg_data = '0;

  stack_scoreboard sb = new();
  int burst_left = 1;

  bounded_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(cmd);
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
    end
  end

  task automatic issue(logic [KIND_W-1:0] k, logic [WORD_W-1:0] v);
    cmd_t c;
    int gap;
    c.kind = k;
    c.value = v;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_stack_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAPACITY_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(logic [CAPACITY_W-1:0] cap, int n, int w_push, int w_pop,
                           int w_peek, int w_clear, int w_search);
    int issued;
    int roll;
    logic [KIND_W-1:0] k;
    logic [WORD_W-1:0] v;
    write_capacity(cap);
    issued = 0;
    while (issued < n) begin
      roll = $urandom_range(0, w_push + w_pop + w_peek + w_clear + w_search + 1);
      if (roll < w_push) k = KIND_PUSH;
      else if (roll < w_push + w_pop) k = KIND_POP;
      else if (roll < w_push + w_pop + w_peek) k = KIND_PEEK;
      else if (roll < w_push + w_pop + w_peek + w_clear) k = KIND_CLEAR;
      else if (roll < w_push + w_pop + w_peek + w_clear + w_search) k = KIND_SEARCH;
      else k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      v = pick_word();
      if (k == KIND_SEARCH && sb.held > 0 && $urandom_range(0, 4) < 3) begin
        v = sb.words[$urandom_range(0, sb.held - 1)];
      end
      issue(k, v);
      if (k <= KIND_SEARCH) issued++;
    end
    wait_stack_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(KIND_POP, 32'h0);
    issue(KIND_PEEK, 32'h0);
    issue(KIND_SEARCH, 32'h0);
    issue(KIND_PUSH, 32'h8000_0000);
    issue(KIND_PUSH, 32'h7FFF_FFFF);
    issue(KIND_PUSH, 32'h0);
    issue(KIND_PUSH, 32'hFFFF_FFFF);
    issue(KIND_PUSH, 32'h7FFF_FFFF);
    issue(KIND_PEEK, 32'h0);
    issue(KIND_SEARCH, 32'h7FFF_FFFF);
    issue(KIND_SEARCH, 32'h8000_0000);
    issue(KIND_SEARCH, 32'h0000_1234);
    issue(KIND_UNUSED_LO, 32'hFFFF_FFFF);
    issue(KIND_UNUSED_HI, 32'h5555_AAAA);
    issue(KIND_POP, 32'h0);
    issue(KIND_POP, 32'h0);
    issue(KIND_CLEAR, 32'h0);
    issue(KIND_PEEK, 32'h0);
    issue(KIND_SEARCH, 32'h0);
    wait_stack_idle();

    run_phase(9'd0, 40, 40, 20, 15, 5, 20);
    run_phase(9'd1, 100, 35, 25, 15, 5, 20);
    run_phase(9'd4, 200, 35, 25, 15, 5, 20);
    run_phase(9'd511, 600, 65, 12, 8, 0, 15);
    run_phase(9'd3, 150, 20, 50, 10, 0, 20);
    run_phase(9'd256, 300, 40, 25, 10, 3, 22);
    run_phase(9'd17, 260, 35, 25, 10, 5, 25);

    repeat (4) @(posedge clk);
    $display("Checked %0d results over %0d capacity settings; deepest stack %0d entries.",
             sb.checked, sb.settings, sb.peak);
    $display("Requests: %0d push, %0d pop, %0d peek, %0d clear, %0d search; %0d refused.",
             sb.kind_seen[KIND_PUSH], sb.kind_seen[KIND_POP], sb.kind_seen[KIND_PEEK],
             sb.kind_seen[KIND_CLEAR], sb.kind_seen[KIND_SEARCH], sb.refused);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
